// ===== design/sliding_window_mean_max_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SLIDING_WINDOW_MEAN_MAX_MACROS_SVH
`define SLIDING_WINDOW_MEAN_MAX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swmm check failed");

// Next-cycle implication, disabled during reset.
`define SWMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swmm check failed");

// Next-cycle implication that also holds across reset.
`define SWMM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("swmm check failed");

`endif

// ===== design/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared sizes, channel codes and control types for the sliding-window
// mean and maximum block.
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

  localparam int WINDOW = 10;
  localparam int DATA_W = 24;
  // Fill count holds 0..WINDOW
  localparam int CNT_W  = $clog2(WINDOW + 1);
  // Signed running sum that never overflows
  localparam int SUM_W  = DATA_W + 1 + $clog2(WINDOW + 1);
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam logic [1:0] CH_TEMP  = 2'd0;
  localparam logic [1:0] CH_HUMID = 2'd1;
  localparam logic [1:0] CH_PRESS = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  typedef struct packed {
    logic push;
    logic rotate;
  } chain_ctl_t;

endpackage

`default_nettype wire

// ===== design/sliding_window_mean_max.sv =====
// Flow: an input transaction pushes the sample, then the block scans the
// window for the maxima while the two bit-serial dividers form the means.
// One item in flight: input is taken again once the result is loaded into
// the output register.
// Reset (rst, synchronous): clears fill counts, sums, pressure history and
// the output valid; window entries stay unknown until written.
// ----------------------------------------------------------------------------
// sliding_window_mean_max
// Per-channel window mean and maximum plus pressure-difference statistics,
// built from rotating cell chains and two serial dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_mean_max (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  channel,
  input  wire logic [swmm_pkg::DATA_W-1:0] sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [swmm_pkg::DATA_W-1:0] window_mean,
  output logic      [swmm_pkg::DATA_W-1:0] window_max,
  output logic      [swmm_pkg::DATA_W-1:0] delta_mean,
  output logic      [swmm_pkg::DATA_W-1:0] delta_max
);
  import swmm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic              acc;
  logic [1:0]        ch_q;
  logic              start_q;
  logic [CNT_W-1:0]  k;

  logic [CNT_W-1:0]  fill [3];
  logic [SUM_W-1:0]  sum  [4];
  logic [DATA_W-1:0] last_pressure;
  logic              pressure_seen;

  chain_ctl_t        ctl  [4];
  logic [DATA_W-1:0] din  [4];
  logic [DATA_W-1:0] tail [4];

  logic [DATA_W:0]   diff;
  logic [DATA_W:0]   diff_abs;
  logic [DATA_W-1:0] delta;

  logic [CNT_W-1:0]  nw;
  logic [CNT_W:0]    pos_w;
  logic [CNT_W:0]    pos_d;
  logic              valid_w;
  logic              valid_d;
  logic [DATA_W-1:0] wmax;
  logic              wfound;
  logic [DATA_W-1:0] dmax;
  logic              dfound;
  logic [SUM_W-1:0]  wsum;
  logic [DATA_W-1:0] wtail;

  logic              busy_w;
  logic              busy_d;
  logic [DATA_W-1:0] q_w;
  logic [DATA_W-1:0] q_d;
  logic              load_out;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid & in_ready;

  // Absolute pressure step; zero for the first pressure sample
  assign diff     = {sample[DATA_W-1], sample} - {last_pressure[DATA_W-1], last_pressure};
  assign diff_abs = diff[DATA_W] ? (~diff + 1'b1) : diff;
  assign delta    = pressure_seen ? diff_abs[DATA_W-1:0] : '0;

  // Chain controls: push on accept, rotate while scanning
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      ctl[g].push   = acc && ((g == 3) ? (channel == CH_PRESS) : (channel == 2'(g)));
      ctl[g].rotate = (state == S_SCAN) && ((g == 3) || (ch_q == 2'(g)));
      din[g]        = (g == 3) ? delta : sample;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_chain
    swmm_chain u_chain (
      .clk  (clk),
      .ctl  (ctl[g]),
      .din  (din[g]),
      .tail (tail[g])
    );
  end

  // Update counts, sums and pressure history on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        fill[c] <= '0;
      end
      for (int c = 0; c < 4; c++) begin
        sum[c] <= '0;
      end
      last_pressure <= '0;
      pressure_seen <= 1'b0;
    end else if (acc) begin
      for (int c = 0; c < 3; c++) begin
        if (channel == 2'(c)) begin
          if (fill[c] == CNT_W'(WINDOW)) begin
            sum[c] <= sum[c] + {{(SUM_W-DATA_W){sample[DATA_W-1]}}, sample}
                      - {{(SUM_W-DATA_W){tail[c][DATA_W-1]}}, tail[c]};
          end else begin
            sum[c]  <= sum[c] + {{(SUM_W-DATA_W){sample[DATA_W-1]}}, sample};
            fill[c] <= fill[c] + 1'b1;
          end
        end
      end
      if (channel == CH_PRESS) begin
        if (fill[2] == CNT_W'(WINDOW)) begin
          sum[3] <= sum[3] + {{(SUM_W-DATA_W){1'b0}}, delta}
                    - {{(SUM_W-DATA_W){1'b0}}, tail[3]};
        end else begin
          sum[3] <= sum[3] + {{(SUM_W-DATA_W){1'b0}}, delta};
        end
        last_pressure <= sample;
        pressure_seen <= 1'b1;
      end
    end
  end

  // Window fill, sum and tail of the latched channel
  always_comb begin
    case (ch_q)
      CH_TEMP:  begin nw = fill[0]; wsum = sum[0]; wtail = tail[0]; end
      CH_HUMID: begin nw = fill[1]; wsum = sum[1]; wtail = tail[1]; end
      CH_PRESS: begin nw = fill[2]; wsum = sum[2]; wtail = tail[2]; end
      default:  begin nw = '0;      wsum = '0;     wtail = tail[0]; end
    endcase
  end

  // Tail entry at scan step k is valid once k reaches WINDOW - fill
  assign pos_w   = {1'b0, k} + {1'b0, nw};
  assign pos_d   = {1'b0, k} + {1'b0, fill[2]};
  assign valid_w = (pos_w >= (CNT_W+1)'(WINDOW));
  assign valid_d = (pos_d >= (CNT_W+1)'(WINDOW));

  swmm_div u_div_w (
    .clk      (clk),
    .rst      (rst),
    .start    (start_q),
    .dividend (wsum),
    .divisor  (nw),
    .busy     (busy_w),
    .quotient (q_w)
  );

  swmm_div u_div_d (
    .clk      (clk),
    .rst      (rst),
    .start    (start_q),
    .dividend (sum[3]),
    .divisor  (fill[2]),
    .busy     (busy_d),
    .quotient (q_d)
  );

  assign load_out = (state == S_DONE) && !busy_w && !busy_d && (!out_valid || out_ready);

  // Sequencer: accept, scan the chains, wait for the dividers, hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      start_q <= 1'b0;
      k       <= '0;
    end else begin
      start_q <= acc;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            state <= S_SCAN;
            k     <= '0;
          end
        end
        S_SCAN: begin
          k <= k + 1'b1;
          if (k == CNT_W'(WINDOW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch channel; track running maxima over the rotating tails
  always_ff @(posedge clk) begin
    if (acc) begin
      ch_q   <= channel;
      wfound <= 1'b0;
      dfound <= 1'b0;
    end else if (state == S_SCAN) begin
      if (valid_w && (!wfound || ($signed(wtail) > $signed(wmax)))) begin
        wmax   <= wtail;
        wfound <= 1'b1;
      end
      if (valid_d && (!dfound || (tail[3] > dmax))) begin
        dmax   <= tail[3];
        dfound <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      window_mean <= (nw != '0) ? q_w : '0;
      window_max  <= wfound ? wmax : '0;
      delta_mean  <= (fill[2] != '0) ? q_d : '0;
      delta_max   <= dfound ? dmax : '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/swmm_cell.sv =====
// ----------------------------------------------------------------------------
// swmm_cell
// One window entry: loads from its neighbor when the chain moves.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_cell (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [swmm_pkg::DATA_W-1:0] d,
  output logic      [swmm_pkg::DATA_W-1:0] q
);
  import swmm_pkg::*;

  // Advance the entry
  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== design/swmm_chain.sv =====
// ----------------------------------------------------------------------------
// swmm_chain
// Row of WINDOW cells. A push shifts a new sample in at the head; a rotate
// feeds the tail back to the head so the whole window passes the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_chain (
  input  wire logic                        clk,
  input  wire swmm_pkg::chain_ctl_t        ctl,
  input  wire logic [swmm_pkg::DATA_W-1:0] din,
  output logic      [swmm_pkg::DATA_W-1:0] tail
);
  import swmm_pkg::*;

  logic [DATA_W-1:0] q [WINDOW];
  logic              en;

  assign en   = ctl.push | ctl.rotate;
  assign tail = q[WINDOW-1];

  // Build the row; the head takes the new sample or the wrapped tail
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell u_cell (
        .clk (clk),
        .en  (en),
        .d   (ctl.push ? din : q[WINDOW-1]),
        .q   (q[i])
      );
    end else begin : g_body
      swmm_cell u_cell (
        .clk (clk),
        .en  (en),
        .d   (q[i-1]),
        .q   (q[i])
      );
    end
  end

endmodule

`default_nettype wire

// ===== design/swmm_div.sv =====
// ----------------------------------------------------------------------------
// swmm_div
// Bit-serial restoring divider: signed running sum by unsigned fill count,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [swmm_pkg::SUM_W-1:0] dividend,
  input  wire logic [swmm_pkg::CNT_W-1:0] divisor,
  output logic                            busy,
  output logic      [swmm_pkg::DATA_W-1:0] quotient
);
  import swmm_pkg::*;

  logic              neg;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    trial;
  logic [SUM_W-1:0]  quo_signed;

  assign rem_sh     = {rem, quo[SUM_W-1]};
  assign trial      = rem_sh - {1'b0, dvs};
  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[DATA_W-1:0];

  // Control: count down one step per bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: load magnitude, then shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[CNT_W]) begin
        rem <= trial[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/swmm_checker.sv =====
// ----------------------------------------------------------------------------
// swmm_checker
// Port-level checks on the sliding-window block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_mean_max_macros.svh"

module swmm_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [swmm_pkg::DATA_W-1:0] window_mean,
  input wire logic [swmm_pkg::DATA_W-1:0] window_max,
  input wire logic [swmm_pkg::DATA_W-1:0] delta_mean,
  input wire logic [swmm_pkg::DATA_W-1:0] delta_max
);
  import swmm_pkg::*;

  // No result right after reset
  `SWMM_ASSERT_RST(a_rst_idle, rst, !out_valid)

  // One item in flight: input closes after a transaction
  `SWMM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // Mean never exceeds maximum
  `SWMM_ASSERT_NOW(a_win_order, out_valid, $signed(window_mean) <= $signed(window_max))
  `SWMM_ASSERT_NOW(a_delta_order, out_valid, delta_mean <= delta_max)

  // Stalled result holds: valid stays high and window_mean is stable
  `SWMM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(window_mean))

endmodule

bind sliding_window_mean_max swmm_checker u_swmm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .window_mean (window_mean),
  .window_max  (window_max),
  .delta_mean  (delta_mean),
  .delta_max   (delta_max)
);

`default_nettype wire
